/* hw/rtl/u8d_pkg.sv */
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;

	// continuation counts of an open sequence
	localparam logic [1:0] CONT_NONE  = 2'd0;
	localparam logic [1:0] CONT_ONE   = 2'd1;
	localparam logic [1:0] CONT_TWO   = 2'd2;
	localparam logic [1:0] CONT_THREE = 2'd3;

	// lead and continuation byte masks and patterns
	localparam logic [7:0] MASK_TOP1 = 8'h80;
	localparam logic [7:0] MASK_TOP2 = 8'hC0;
	localparam logic [7:0] MASK_TOP3 = 8'hE0;
	localparam logic [7:0] MASK_TOP4 = 8'hF0;
	localparam logic [7:0] MASK_TOP5 = 8'hF8;
	localparam logic [7:0] PAT_CONT  = 8'h80;
	localparam logic [7:0] PAT_LEAD2 = 8'hC0;
	localparam logic [7:0] PAT_LEAD3 = 8'hE0;
	localparam logic [7:0] PAT_LEAD4 = 8'hF0;

	// code point limits
	localparam logic [CP_W-1:0] CP_MIN2        = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN3        = 21'h000800;
	localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_END    = 21'h00E000;
	localparam logic [CP_W-1:0] CP_MIN4        = 21'h010000;
	localparam logic [CP_W-1:0] CP_LIMIT       = 21'h110000;
	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

	// byte held in the input register
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} byte_stage_t;

	// result handed to the output register
	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] code_point;
		logic            was_error;
	} cp_stage_t;

endpackage

/* hw/rtl/u8d_byte_if.sv */
// byte channel: valid, ready and one raw byte
interface u8d_byte_if;
	import u8d_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/u8d_cp_if.sv */
// code point channel: valid, ready, code point and error flag
interface u8d_cp_if;
	import u8d_pkg::*;

	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            was_error;

	modport source (output valid, output code_point, output was_error, input ready);
	modport sink (input valid, input code_point, input was_error, output ready);
endinterface

/* hw/rtl/u8d_in_reg.sv */
// input register: holds one accepted byte until the decoder takes it
module u8d_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	u8d_byte_if.sink            bytes,
	input  logic                take,
	output u8d_pkg::byte_stage_t stage
);
	import u8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              load;

	// accept when empty or when the held byte moves on this cycle
	assign bytes.ready = !valid_s1 || take;
	assign load        = bytes.valid && bytes.ready;

	// control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= bytes.in_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = byte_s1;
endmodule

/* hw/rtl/u8d_decode.sv */
// sequence state and single-pass decode of the held byte
module u8d_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u8d_pkg::byte_stage_t stage,
	input  logic                 out_free,
	output logic                 take,
	output u8d_pkg::cp_stage_t   result
);
	import u8d_pkg::*;

	logic [1:0]        pending_q;
	logic [1:0]        seq_len_q;
	logic [CP_W-1:0]   partial_q;
	logic [1:0]        pending_n;
	logic [1:0]        seq_len_n;
	logic [CP_W-1:0]   partial_n;
	logic [CP_W-1:0]   acc;
	logic [BYTE_W-1:0] b;
	logic              emit;
	logic              value_ok;
	logic [CP_W-1:0]   cp_n;
	logic              err_n;

	assign b   = stage.data;
	assign acc = {partial_q[CP_W-7:0], b[5:0]};

	// range check of a finished sequence by its length
	always_comb begin
		case (seq_len_q)
			CONT_ONE:   value_ok = (acc >= CP_MIN2);
			CONT_TWO:   value_ok = (acc >= CP_MIN3) &&
				((acc < CP_SURR_LO) || (acc >= CP_SURR_END));
			CONT_THREE: value_ok = (acc >= CP_MIN4) && (acc < CP_LIMIT);
			default:    value_ok = (acc >= CP_MIN4) && (acc < CP_LIMIT);
		endcase
	end

	// next state and result for the held byte
	always_comb begin
		pending_n = pending_q;
		seq_len_n = seq_len_q;
		partial_n = partial_q;
		emit      = 1'b0;
		cp_n      = CP_REPLACEMENT;
		err_n     = 1'b1;
		if (pending_q == CONT_NONE) begin
			if ((b & MASK_TOP1) == '0) begin
				emit  = 1'b1;
				cp_n  = {{(CP_W-BYTE_W){1'b0}}, b};
				err_n = 1'b0;
			end else if ((b & MASK_TOP3) == PAT_LEAD2) begin
				partial_n = {{(CP_W-5){1'b0}}, b[4:0]};
				seq_len_n = CONT_ONE;
				pending_n = CONT_ONE;
			end else if ((b & MASK_TOP4) == PAT_LEAD3) begin
				partial_n = {{(CP_W-4){1'b0}}, b[3:0]};
				seq_len_n = CONT_TWO;
				pending_n = CONT_TWO;
			end else if ((b & MASK_TOP5) == PAT_LEAD4) begin
				partial_n = {{(CP_W-3){1'b0}}, b[2:0]};
				seq_len_n = CONT_THREE;
				pending_n = CONT_THREE;
			end else begin
				emit = 1'b1;
			end
		end else if ((b & MASK_TOP2) != PAT_CONT) begin
			// broken sequence: drop it and consume this byte
			pending_n = CONT_NONE;
			partial_n = '0;
			emit      = 1'b1;
		end else begin
			pending_n = pending_q - 2'd1;
			if (pending_n != CONT_NONE) begin
				partial_n = acc;
			end else begin
				partial_n = '0;
				emit      = 1'b1;
				if (value_ok) begin
					cp_n  = acc;
					err_n = 1'b0;
				end
			end
		end
	end

	// a byte moves on unless its result would hit a full output register
	assign take = stage.valid && (!emit || out_free);

	assign result.valid      = take && emit;
	assign result.code_point = cp_n;
	assign result.was_error  = err_n;

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= CONT_NONE;
			seq_len_q <= CONT_NONE;
			partial_q <= '0;
		end else if (take) begin
			pending_q <= pending_n;
			seq_len_q <= seq_len_n;
			partial_q <= partial_n;
		end
	end
endmodule

/* hw/rtl/u8d_out_reg.sv */
// result register: holds one code point until the receiver takes it
module u8d_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  u8d_pkg::cp_stage_t result,
	output logic               out_free,
	u8d_cp_if.source           points
);
	import u8d_pkg::*;

	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            err_q;

	assign out_free = !valid_q || points.ready;

	// control bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.valid) begin
			valid_q <= 1'b1;
		end else if (points.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (result.valid) begin
			cp_q  <= result.code_point;
			err_q <= result.was_error;
		end
	end

	assign points.valid      = valid_q;
	assign points.code_point = cp_q;
	assign points.was_error  = err_q;
endmodule

/* hw/rtl/utf8_stream_decoder.sv */
// UTF-8 stream decoder, one byte in per cycle, at most one code point out per byte
//
// bytes:  sink channel, one raw UTF-8 byte per item (valid/ready).
// points: source channel, one decoded code point and error flag per item.
// A byte accepted on bytes is held in the input register and decoded there
// against the sequence state; its code point (if any) is then stored in
// the result register and appears on points from there.
// While points does not stall, one byte is taken per cycle; the decode of
// the held byte and the sequence state update are one pass of shallow
// logic between the input register and the result register.
// Lead and middle continuation bytes give no item; ASCII, completed
// sequences and malformed input give one (0xFFFD with was_error on error).
// A sequence left unfinished simply stays open; there is no flush.
// Reset clears both registers' valid bits and the sequence state.
// When points stalls, the result register holds; a byte that gives no
// item still moves on, a byte that would give one waits in the input
// register, and bytes.ready drops once that register is full.
module utf8_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	u8d_byte_if.sink   bytes,
	u8d_cp_if.source   points
);
	import u8d_pkg::*;

	byte_stage_t stage;
	cp_stage_t   result;
	logic        take;
	logic        out_free;

	u8d_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.take   (take),
		.stage  (stage)
	);

	u8d_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage    (stage),
		.out_free (out_free),
		.take     (take),
		.result   (result)
	);

	u8d_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.out_free (out_free),
		.points   (points)
	);
endmodule
